[rtl/h2df_pkg.sv]
// ----------------------------------------------------------------------------
// h2df_pkg
// shared types and constants for the http/2 frame deframer
// ----------------------------------------------------------------------------
package h2df_pkg;

  // field widths
  localparam int unsigned LenW    = 24;
  localparam int unsigned SidW    = 31;
  localparam int unsigned HdrBufN = 8;
  localparam int unsigned HdrCntW = 4;

  // register reset value
  localparam logic [LenW-1:0] MaxPayloadReset = 24'd16384;

  // http/1 reply signature as seen through a frame header ("HTTP/")
  localparam logic [LenW-1:0] Http1Len   = 24'h485454;
  localparam logic [7:0]      Http1Type  = 8'h50;
  localparam logic [7:0]      Http1Flags = 8'h2F;

  // input item kinds
  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_END  = 1'b1
  } action_t;

  // result item kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SIZE_ERR = 2'd1,
    ST_PROTO    = 2'd2
  } status_t;

  // one result word
  typedef struct packed {
    kind_t           kind;
    logic [7:0]      payload_byte;
    logic [LenW-1:0] frm_len;
    logic [7:0]      frm_type;
    logic [7:0]      frame_flags;
    logic [SidW-1:0] frm_sid;
    status_t         status;
    logic            last_of_frame;
  } result_t;

endpackage

[rtl/http2_frame_deframer_core.sv]
// ----------------------------------------------------------------------------
// http2_frame_deframer_core
// http/2 frame header parser and payload pass-through
// ----------------------------------------------------------------------------
// an accepted word is held in the input register, its result in the result register
// throughput: one input word per cycle while results drain, set by the input and
// result registers; a word that yields no result still passes the parse stage
// reset: synchronous rst clears valid flags, frame state and the halt flag
// and loads max_payload with 16384; the header store is not cleared
// ----------------------------------------------------------------------------
module http2_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write: max_payload
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tuser,  // [0] action
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [31:8] frm_len, [39:32] frm_type,
  // [47:40] frame_flags, [78:48] frm_sid, [80:79] status, [87:81] zero
  output logic [87:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,  // [1:0] kind
  output logic        m_axis_tlast   // last_of_frame
);
  import h2df_pkg::*;

  logic       item_valid;
  action_t    item_action;
  logic [7:0] item_data;
  logic       out_free;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // register always takes writes
  assign cfg_ready = 1'b1;

  // held word moves on when the result register has room
  assign fire = item_valid && out_free;

  h2df_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (out_free),
    .item_valid    (item_valid),
    .item_action   (item_action),
    .item_data     (item_data)
  );

  h2df_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .fire        (fire),
    .item_action (item_action),
    .item_data   (item_data),
    .res_valid   (res_valid),
    .res         (res)
  );

  h2df_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // pack result fields onto the stream
  assign m_axis_tdata = {7'b0, out_res.status, out_res.frm_sid, out_res.frame_flags,
                         out_res.frm_type, out_res.frm_len, out_res.payload_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last_of_frame;

endmodule

[rtl/h2df_in_reg.sv]
// ----------------------------------------------------------------------------
// h2df_in_reg
// input register stage; takes a new word whenever the parser can advance
// ----------------------------------------------------------------------------
module h2df_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tuser,
  input  logic              advance,
  output logic              item_valid,
  output h2df_pkg::action_t item_action,
  output logic [7:0]        item_data
);
  import h2df_pkg::*;

  logic item_valid_next;

  // free when empty or when the held word moves on this cycle
  assign s_axis_tready = !item_valid || advance;

  // valid flag
  always_comb begin
    item_valid_next = item_valid;
    if (s_axis_tvalid && s_axis_tready) begin
      item_valid_next = 1'b1;
    end else if (advance) begin
      item_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_action <= action_t'(s_axis_tuser);
      item_data   <= s_axis_tdata;
    end
  end

endmodule

[rtl/h2df_parse.sv]
// ----------------------------------------------------------------------------
// h2df_parse
// frame state and single-pass parse of one word into at most one result
// ----------------------------------------------------------------------------
module h2df_parse (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic [h2df_pkg::LenW-1:0]        cfg_data,
  input  logic                             fire,
  input  h2df_pkg::action_t                item_action,
  input  logic [7:0]                       item_data,
  output logic                             res_valid,
  output h2df_pkg::result_t                res
);
  import h2df_pkg::*;

  logic [LenW-1:0]    max_payload;
  logic [7:0]         header_store [HdrBufN];
  logic [HdrCntW-1:0] header_count;
  logic [HdrCntW-1:0] header_count_next;
  logic [LenW-1:0]    bytes_left;
  logic [LenW-1:0]    bytes_left_next;
  logic               in_payload;
  logic               in_payload_next;
  logic               halted;
  logic               halted_next;
  logic               store_we;
  logic [LenW-1:0]    left_dec;
  logic [LenW-1:0]    hdr_len;
  logic [SidW-1:0]    hdr_sid;
  logic               http1_sig;

  // header fields from the stored bytes plus the ninth byte
  assign hdr_len   = {header_store[0], header_store[1], header_store[2]};
  assign hdr_sid   = {header_store[5][6:0], header_store[6], header_store[7], item_data};
  assign http1_sig = (hdr_len == Http1Len) && (header_store[3] == Http1Type) &&
                     (header_store[4] == Http1Flags);
  assign left_dec  = bytes_left - LenW'(1);

  // next state and result
  always_comb begin
    header_count_next = header_count;
    bytes_left_next   = bytes_left;
    in_payload_next   = in_payload;
    halted_next       = halted;
    store_we          = 1'b0;
    res_valid         = 1'b0;
    res               = '0;
    if (fire && !halted) begin
      if (item_action == ACT_END) begin
        // end of input: clean at a frame boundary, truncation otherwise
        res_valid = 1'b1;
        res.kind  = KIND_END;
        if (in_payload || (header_count != '0)) begin
          halted_next = 1'b1;
          res.status  = ST_SIZE_ERR;
        end else begin
          res.status = ST_OK;
        end
      end else if (in_payload) begin
        // payload byte passes through
        bytes_left_next   = left_dec;
        in_payload_next   = (left_dec != '0);
        res_valid         = 1'b1;
        res.kind          = KIND_PAYLOAD;
        res.payload_byte  = item_data;
        res.status        = ST_OK;
        res.last_of_frame = (left_dec == '0);
      end else if (header_count < HdrCntW'(HdrBufN)) begin
        // gather header bytes
        store_we          = 1'b1;
        header_count_next = header_count + HdrCntW'(1);
      end else begin
        // ninth header byte completes the header
        header_count_next = '0;
        res_valid         = 1'b1;
        res.frm_len       = hdr_len;
        res.frm_type      = header_store[3];
        res.frame_flags   = header_store[4];
        res.frm_sid       = hdr_sid;
        if (hdr_len > max_payload) begin
          halted_next = 1'b1;
          res.kind    = KIND_END;
          res.status  = http1_sig ? ST_PROTO : ST_SIZE_ERR;
        end else begin
          bytes_left_next   = hdr_len;
          in_payload_next   = (hdr_len != '0);
          res.kind          = KIND_HEADER;
          res.status        = ST_OK;
          res.last_of_frame = (hdr_len == '0);
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload  <= MaxPayloadReset;
      header_count <= '0;
      bytes_left   <= '0;
      in_payload   <= 1'b0;
      halted       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_payload <= cfg_data;
      end
      header_count <= header_count_next;
      bytes_left   <= bytes_left_next;
      in_payload   <= in_payload_next;
      halted       <= halted_next;
    end
  end

  // header byte store, written in arrival order
  always_ff @(posedge clk) begin
    if (store_we) begin
      header_store[header_count[$clog2(HdrBufN)-1:0]] <= item_data;
    end
  end

endmodule

[rtl/h2df_out_reg.sv]
// ----------------------------------------------------------------------------
// h2df_out_reg
// result register toward the master side
// ----------------------------------------------------------------------------
module h2df_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_valid,
  input  h2df_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output h2df_pkg::result_t out_res
);
  import h2df_pkg::*;

  logic out_valid_next;

  // room for a new result when empty or being drained
  assign out_free = !out_valid || out_ready;

  // valid flag
  always_comb begin
    out_valid_next = out_valid;
    if (out_free) begin
      out_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule
